/* src/mldb_pkg.sv */
// ----------------------------------------------------------------------------
// mldb_pkg
// Shared types, constants and helpers of the 2x2 box-filter mip downsampler.
// ----------------------------------------------------------------------------
package mldb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int DIM_W      = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int OY_W       = ROW_W - 1;
    localparam int LANE_W     = 10;
    localparam int PAIR_W     = 4 * LANE_W;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [0:0] REG_SRC_WIDTH  = 1'b0;
    localparam logic [0:0] REG_SRC_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       level_done;
    } out_t;

    typedef struct packed {
        logic               w_one;
        logic               h_one;
        logic [COL_W-1:0]   w_last;
        logic [ROW_W-1:0]   h_last;
        logic [COL_W:0]     w_used;
        logic [ROW_W:0]     h_used;
        logic [LINE_AW-1:0] ox_last;
        logic [OY_W-1:0]    oy_last;
    } dims_t;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_EMIT_LINE = 2'd1,
        OP_EMIT_DUP  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [LINE_AW-1:0] ox;
        logic [PAIR_W-1:0]  pair;
        logic               last;
    } qitem_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic at_origin;
    } fr_stat_t;

    typedef struct packed {
        logic s1_valid;
    } bk_stat_t;

    function automatic logic [PAIR_W-1:0] pair_of(in_t a, in_t b);
        logic [LANE_W-1:0] r;
        logic [LANE_W-1:0] g;
        logic [LANE_W-1:0] bl;
        logic [LANE_W-1:0] al;
        r  = {2'b00, a.in_red}   + {2'b00, b.in_red};
        g  = {2'b00, a.in_green} + {2'b00, b.in_green};
        bl = {2'b00, a.in_blue}  + {2'b00, b.in_blue};
        al = {2'b00, a.in_alpha} + {2'b00, b.in_alpha};
        return {al, bl, g, r};
    endfunction

    function automatic logic [7:0] lane_avg(logic [LANE_W-1:0] s);
        logic [LANE_W:0] t;
        t = {1'b0, s} + (LANE_W+1)'(2);
        return t[LANE_W-1:2];
    endfunction

endpackage

/* src/mldb_cfg.sv */
// ----------------------------------------------------------------------------
// mldb_cfg
// APB register file for source dimensions; derives clamped level geometry.
// ----------------------------------------------------------------------------
module mldb_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mldb_pkg::PADDR_W-1:0]   paddr,
    input  logic [mldb_pkg::PDATA_W-1:0]   pwdata,
    output logic [mldb_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output logic                           restart,
    output mldb_pkg::dims_t                dims
);
    import mldb_pkg::*;

    logic [DIM_W-1:0] src_width_reg;
    logic [DIM_W-1:0] src_height_reg;
    logic [0:0]       reg_idx;
    logic             wr_en;
    int               w_int;
    int               h_int;
    logic [COL_W:0]   w_eff;
    logic [ROW_W:0]   h_eff;
    logic [COL_W-1:0] ow;
    logic [ROW_W-1:0] oh;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite;
    assign restart = wr_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DIM_W'(1);
            src_height_reg <= DIM_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_reg);
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        w_int = int'(src_width_reg);
        h_int = int'(src_height_reg);
        if (w_int == 0) begin
            w_eff = (COL_W+1)'(1);
        end else if (w_int > MAX_WIDTH) begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end else begin
            w_eff = (COL_W+1)'(w_int);
        end
        if (h_int == 0) begin
            h_eff = (ROW_W+1)'(1);
        end else if (h_int > MAX_HEIGHT) begin
            h_eff = (ROW_W+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (ROW_W+1)'(h_int);
        end
        ow = w_eff[COL_W:1];
        if (ow == '0) begin
            ow = COL_W'(1);
        end
        oh = h_eff[ROW_W:1];
        if (oh == '0) begin
            oh = ROW_W'(1);
        end
        dims.w_one   = (w_eff == (COL_W+1)'(1));
        dims.h_one   = (h_eff == (ROW_W+1)'(1));
        dims.w_last  = COL_W'(w_eff - (COL_W+1)'(1));
        dims.h_last  = ROW_W'(h_eff - (ROW_W+1)'(1));
        dims.w_used  = {ow, 1'b0};
        dims.h_used  = {oh, 1'b0};
        dims.ox_last = LINE_AW'(ow - COL_W'(1));
        dims.oy_last = OY_W'(oh - ROW_W'(1));
    end

endmodule

/* src/mldb_front.sv */
// ----------------------------------------------------------------------------
// mldb_front
// Source pixel intake: position tracking, horizontal pairing, classification.
// ----------------------------------------------------------------------------
module mldb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  mldb_pkg::dims_t   dims,
    input  logic              s_valid,
    output logic              s_ready,
    input  mldb_pkg::in_t     s_data,
    input  mldb_pkg::q_stat_t q_stat,
    output logic              q_push,
    output mldb_pkg::qitem_t  q_item,
    output mldb_pkg::fr_stat_t fr_stat
);
    import mldb_pkg::*;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    in_t              held_reg;
    in_t              held_next;
    logic             take;
    logic             have_pair;
    logic [PAIR_W-1:0] pair;
    logic [LINE_AW-1:0] ox;
    logic             emit_ok;

    assign s_ready           = ~q_stat.full;
    assign take              = s_valid & s_ready;
    assign fr_stat.at_origin = (col_reg == '0) && (row_reg == '0) && (held_reg == '0);

    always_comb begin
        held_next = held_reg;
        have_pair = 1'b0;
        pair      = pair_of(s_data, s_data);
        ox        = '0;
        if (dims.w_one) begin
            have_pair = (col_reg == '0);
        end else if ({1'b0, col_reg} < dims.w_used) begin
            if (!col_reg[0]) begin
                held_next = s_data;
            end else begin
                pair      = pair_of(held_reg, s_data);
                have_pair = 1'b1;
                ox        = col_reg[COL_W-1:1];
            end
        end

        emit_ok     = 1'b0;
        q_item.op   = OP_WRITE;
        q_item.ox   = ox;
        q_item.pair = pair;
        q_item.last = 1'b0;
        if (have_pair) begin
            if (dims.h_one) begin
                if (row_reg == '0) begin
                    emit_ok     = 1'b1;
                    q_item.op   = OP_EMIT_DUP;
                    q_item.last = (ox == dims.ox_last);
                end
            end else if ({1'b0, row_reg} < dims.h_used) begin
                emit_ok = 1'b1;
                if (row_reg[0]) begin
                    q_item.op   = OP_EMIT_LINE;
                    q_item.last = (ox == dims.ox_last)
                               && (row_reg[ROW_W-1:1] == dims.oy_last);
                end
            end
        end
        q_push = take & emit_ok;

        if (col_reg == dims.w_last) begin
            col_next = '0;
            row_next = (row_reg == dims.h_last) ? '0 : row_reg + ROW_W'(1);
        end else begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end else if (take) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

endmodule

/* src/mldb_queue.sv */
// ----------------------------------------------------------------------------
// mldb_queue
// Short FIFO of classified line operations between front and back.
// ----------------------------------------------------------------------------
module mldb_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mldb_pkg::qitem_t  push_item,
    input  logic              pop,
    output mldb_pkg::qitem_t  head,
    output mldb_pkg::q_stat_t stat
);
    import mldb_pkg::*;

    qitem_t         entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic [QAW:0]   count_next;
    logic           do_push;
    logic           do_pop;

    assign stat.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push & ~stat.full;
    assign do_pop     = pop & ~stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QAW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

/* src/mldb_back.sv */
// ----------------------------------------------------------------------------
// mldb_back
// Line store access, vertical sum, rounding and the output register.
// ----------------------------------------------------------------------------
module mldb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  mldb_pkg::qitem_t  head,
    input  mldb_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output mldb_pkg::out_t    m_data,
    output mldb_pkg::bk_stat_t bk_stat
);
    import mldb_pkg::*;

    logic [PAIR_W-1:0] line_mem [LINE_DEPTH];
    logic [PAIR_W-1:0] rd_data_reg;
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [PAIR_W-1:0] s1_pair_reg;
    logic              s1_last_reg;
    logic              m_valid_reg;
    out_t              m_data_reg;
    out_t              m_data_next;
    logic              out_free;
    logic              s1_take;
    logic              s1_room;
    logic              pop_emit;
    logic [LANE_W-1:0] lane_a;
    logic [LANE_W-1:0] lane_b;
    logic [7:0]        avg [4];

    assign out_free         = ~m_valid_reg | m_ready;
    assign s1_take          = s1_valid_reg & out_free;
    assign s1_room          = ~s1_valid_reg | out_free;
    assign pop              = ~q_stat.empty & ((head.op == OP_WRITE) | s1_room);
    assign pop_emit         = pop & (head.op != OP_WRITE);
    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;
    assign bk_stat.s1_valid = s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            case (head.op)
                OP_WRITE:     line_mem[head.ox] <= head.pair;
                OP_EMIT_LINE: rd_data_reg <= line_mem[head.ox];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            lane_a = s1_pair_reg[c*LANE_W +: LANE_W];
            case (s1_op_reg)
                OP_EMIT_LINE: lane_b = rd_data_reg[c*LANE_W +: LANE_W];
                default:      lane_b = lane_a;
            endcase
            avg[c] = lane_avg(lane_a + lane_b);
        end
        m_data_next.out_red    = avg[0];
        m_data_next.out_green  = avg[1];
        m_data_next.out_blue   = avg[2];
        m_data_next.out_alpha  = avg[3];
        m_data_next.level_done = s1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (pop_emit) begin
            s1_op_reg   <= head.op;
            s1_pair_reg <= head.pair;
            s1_last_reg <= head.last;
        end
        if (s1_take) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (pop_emit) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_take) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* src/mip_level_box_downsample_core.sv */
// ----------------------------------------------------------------------------
// mip_level_box_downsample_core
// 2x2 box-filter mip level generator for a raster RGBA8 pixel stream.
//
// Program src_width and src_height over APB while the block is idle; any
// write restarts the level at the top-left pixel. Source pixels enter on the
// s_ valid/ready channel in raster order, one per cycle at full rate. Each
// completed 2x2 square leaves on the m_ channel as one averaged pixel, with
// level_done set on the last pixel of the output level; the next level may
// follow straight after. Pixels of a dropped odd last column or row are
// consumed without a result.
// The pixel that completes a square is written into the queue; its item then
// moves into the registered line store read and the stage-1 registers, and
// is rounded into the output register. With no output stall, throughput is
// one pixel per cycle, set by the single-port line store taking one access a
// cycle. A four-entry queue decouples intake from the store; when the
// receiver stalls, the output register and the queue fill and s_ready drops.
// Reset clears position, held pixel and all valid flags; the line store needs
// no clearing because every entry is written on an even row before use.
// ----------------------------------------------------------------------------
module mip_level_box_downsample_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mldb_pkg::PADDR_W-1:0] paddr,
    input  logic [mldb_pkg::PDATA_W-1:0] pwdata,
    output logic [mldb_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  mldb_pkg::in_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output mldb_pkg::out_t               m_data
);
    import mldb_pkg::*;

    dims_t    dims;
    logic     restart;
    q_stat_t  q_stat;
    logic     q_push;
    qitem_t   q_item;
    qitem_t   q_head;
    logic     q_pop;
    fr_stat_t fr_stat;
    bk_stat_t bk_stat;

    mldb_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .restart (restart),
        .dims    (dims)
    );

    mldb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .dims    (dims),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_item  (q_item),
        .fr_stat (fr_stat)
    );

    mldb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    mldb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .q_stat  (q_stat),
        .pop     (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .bk_stat (bk_stat)
    );

    a_restart_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite) |=> fr_stat.at_origin)
        else $error("position not cleared after register write");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && bk_stat.s1_valid) |=> bk_stat.s1_valid)
        else $error("pending result lost during output stall");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && !bk_stat.s1_valid && q_stat.empty))
        else $error("pipeline not empty after reset");

endmodule

/* tb/sv/mldb_average_checker.sv */
// ----------------------------------------------------------------------------
// mldb_average_checker
// Watches the APB port and both pixel channels of the box-filter downsampler.
// It tracks the source size, predicts each averaged output pixel from the
// accepted source pixels, and compares every result transfer with the
// oldest prediction field by field. APB reads are checked against the
// register values. The mismatch count and the number of results still due
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module mldb_average_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mldb_pkg::PADDR_W-1:0] paddr,
    input  logic [mldb_pkg::PDATA_W-1:0] pwdata,
    input  logic [mldb_pkg::PDATA_W-1:0] prdata,
    input  logic                         pready,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  mldb_pkg::in_t                s_data,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  mldb_pkg::out_t               m_data,
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen
);
    import mldb_pkg::*;

    typedef logic [3:0][LANE_W-1:0] lanes_t;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    in_t              held_pixel;
    lanes_t           pair_line [LINE_DEPTH];
    int               col;
    int               row;
    out_t             expected_pixels [$];
    int               mismatches;
    int               checked;

    assign fail_count   = mismatches;
    assign results_seen = checked;

    task automatic report_mismatch(string what);
        $display("[%0t] mldb mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic int effective_dim(logic [DIM_W-1:0] v, int limit);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > limit) begin
            return limit;
        end
        return int'(v);
    endfunction

    function automatic lanes_t pair_sums(in_t a, in_t b);
        lanes_t r;
        r[0] = LANE_W'(a.in_red)   + LANE_W'(b.in_red);
        r[1] = LANE_W'(a.in_green) + LANE_W'(b.in_green);
        r[2] = LANE_W'(a.in_blue)  + LANE_W'(b.in_blue);
        r[3] = LANE_W'(a.in_alpha) + LANE_W'(b.in_alpha);
        return r;
    endfunction

    function automatic logic [7:0] round_quarter(logic [LANE_W-1:0] s);
        int t;
        t = int'(s) + 2;
        return 8'(t / 4);
    endfunction

    task automatic predict_average(in_t px);
        int     w;
        int     h;
        int     ow;
        int     oh;
        int     ox;
        int     oy;
        int     c;
        logic   got_pair;
        logic   emit;
        lanes_t pair;
        lanes_t total;
        out_t   res;
        w        = effective_dim(width_reg, MAX_WIDTH);
        h        = effective_dim(height_reg, MAX_HEIGHT);
        ow       = (w / 2 != 0) ? w / 2 : 1;
        oh       = (h / 2 != 0) ? h / 2 : 1;
        got_pair = 1'b0;
        emit     = 1'b0;
        ox       = 0;
        oy       = 0;
        pair     = '0;
        total    = '0;
        if (w == 1) begin
            if (col == 0) begin
                pair     = pair_sums(px, px);
                got_pair = 1'b1;
            end
        end else if (col < 2 * ow) begin
            if (col % 2 == 0) begin
                held_pixel = px;
            end else begin
                pair     = pair_sums(held_pixel, px);
                got_pair = 1'b1;
                ox       = col / 2;
            end
        end
        if (got_pair) begin
            if (h == 1) begin
                if (row == 0) begin
                    for (c = 0; c < 4; c++) begin
                        total[c] = pair[c] << 1;
                    end
                    emit = 1'b1;
                end
            end else if (row < 2 * oh) begin
                if (row % 2 == 0) begin
                    pair_line[ox] = pair;
                end else begin
                    for (c = 0; c < 4; c++) begin
                        total[c] = pair_line[ox][c] + pair[c];
                    end
                    emit = 1'b1;
                    oy   = row / 2;
                end
            end
        end
        if (emit) begin
            res.out_red    = round_quarter(total[0]);
            res.out_green  = round_quarter(total[1]);
            res.out_blue   = round_quarter(total[2]);
            res.out_alpha  = round_quarter(total[3]);
            res.level_done = (ox == ow - 1) && (oy == oh - 1);
            expected_pixels.insert(expected_pixels.size(), res);
        end
        if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endtask

    always @(posedge aclk) begin
        out_t             want;
        logic [PDATA_W-1:0] reg_value;
        if (!aresetn) begin
            width_reg  = DIM_W'(1);
            height_reg = DIM_W'(1);
            held_pixel = '0;
            col        = 0;
            row        = 0;
            expected_pixels.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result transfer with no pixel due");
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_data.out_red !== want.out_red) begin
                        report_mismatch($sformatf("result %0d red %0d, want %0d",
                            checked, m_data.out_red, want.out_red));
                    end
                    if (m_data.out_green !== want.out_green) begin
                        report_mismatch($sformatf("result %0d green %0d, want %0d",
                            checked, m_data.out_green, want.out_green));
                    end
                    if (m_data.out_blue !== want.out_blue) begin
                        report_mismatch($sformatf("result %0d blue %0d, want %0d",
                            checked, m_data.out_blue, want.out_blue));
                    end
                    if (m_data.out_alpha !== want.out_alpha) begin
                        report_mismatch($sformatf("result %0d alpha %0d, want %0d",
                            checked, m_data.out_alpha, want.out_alpha));
                    end
                    if (m_data.level_done !== want.level_done) begin
                        report_mismatch($sformatf("result %0d level_done %0b, want %0b",
                            checked, m_data.level_done, want.level_done));
                    end
                    checked++;
                end
            end
            if (psel && penable && pready && paddr[1:0] == 2'b00) begin
                if (pwrite) begin
                    if (paddr[PADDR_W-1:2] == REG_SRC_WIDTH) begin
                        width_reg = pwdata[DIM_W-1:0];
                    end else begin
                        height_reg = pwdata[DIM_W-1:0];
                    end
                    held_pixel = '0;
                    col        = 0;
                    row        = 0;
                end else begin
                    reg_value = (paddr[PADDR_W-1:2] == REG_SRC_WIDTH) ?
                                PDATA_W'(width_reg) : PDATA_W'(height_reg);
                    if (prdata !== reg_value) begin
                        report_mismatch($sformatf("readback at %0d gave %0h, want %0h",
                            paddr, prdata, reg_value));
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_average(s_data);
            end
        end
        pending <= expected_pixels.size();
    end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the 2x2 box-filter mip downsampler.
// A directed opening covers the reset size, channel extremes, rounding, an
// odd size with dropped pixels, zero-sized registers and a long gapless level
// under one long receiver hold-off. Short runs into the largest and clamped
// sizes follow, and a random part runs many small levels, back to back and
// cut short, under bursty input and a stalling receiver. Checking is done by
// mldb_average_checker alongside the block.
// ----------------------------------------------------------------------------
module tb;
    import mldb_pkg::*;

    localparam int CLK_HALF         = 4;
    localparam int LIMIT_CYCLES     = 1000000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int LARGE_RUN_PIXELS = 96;
    localparam int RANDOM_PIXELS    = 425;

    localparam logic [PADDR_W-1:0] ADDR_SRC_WIDTH  = {REG_SRC_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SRC_HEIGHT = {REG_SRC_HEIGHT, 2'b00};

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    in_t                s_data;
    logic               m_valid;
    logic               m_ready;
    out_t               m_data;

    int fail_count;
    int pending;
    int results_seen;

    int burst_left;
    bit gapless;
    bit want_hold;
    int pixels_sent;
    int settings_run;

    mip_level_box_downsample_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mldb_average_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial aclk = 1'b0;

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("mip_level_box_downsample_core verification failed");
        $finish;
    end

    function automatic in_t flat_pixel(logic [7:0] v);
        return {v, v, v, v};
    endfunction

    function automatic in_t random_pixel();
        in_t p;
        p = in_t'(32'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            p.in_red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.in_blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.in_alpha = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // hold until every due result is out and the pipeline has drained
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_level(int w_val, int h_val, output int level_pixels);
        logic [PDATA_W-1:0] upper;
        int                 w_eff;
        int                 h_eff;
        wait_idle();
        upper = $urandom_range(0, 1) ? (32'($urandom) & 32'hFFFF_E000) : '0;
        apb_access(1'b1, ADDR_SRC_WIDTH, upper | (32'(w_val) & 32'h0000_1FFF));
        upper = $urandom_range(0, 1) ? (32'($urandom) & 32'hFFFF_E000) : '0;
        apb_access(1'b1, ADDR_SRC_HEIGHT, upper | (32'(h_val) & 32'h0000_1FFF));
        apb_access(1'b0, ADDR_SRC_WIDTH, '0);
        apb_access(1'b0, ADDR_SRC_HEIGHT, '0);
        w_eff = (w_val == 0) ? 1 : ((w_val > MAX_WIDTH) ? MAX_WIDTH : w_val);
        h_eff = (h_val == 0) ? 1 : ((h_val > MAX_HEIGHT) ? MAX_HEIGHT : h_val);
        level_pixels = w_eff * h_eff;
        burst_left   = 0;
        settings_run++;
    endtask

    task automatic send_pixel(in_t px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gapless) begin
                gap = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 12);
            end else begin
                gap = $urandom_range(0, 2);
            end
            if (gap > 0) begin
                s_valid <= 1'b0;
                s_data  <= in_t'(32'($urandom));
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    initial begin : receiver
        int mode;
        int span;
        bit held_long;
        m_ready  <= 1'b0;
        held_long = 1'b0;
        forever begin
            if (want_hold && !held_long) begin
                held_long = 1'b1;
                repeat (HOLD_OFF_CYCLES) begin
                    @(posedge aclk);
                    m_ready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 9);
            span = $urandom_range(8, 80);
            if (mode == 9 && $urandom_range(0, 3) == 0) begin
                span = $urandom_range(100, 250);
            end
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0, 1, 2: begin
                        m_ready <= 1'b1;
                    end
                    3, 4: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    5, 6: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    7: begin
                        m_ready <= ~m_ready;
                    end
                    8: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        m_ready <= (span < 100);
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        int n;
        int pick;
        int w_val;
        int h_val;
        int total;
        int random_sent;
        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_valid      <= 1'b0;
        s_data       <= '0;
        burst_left    = 0;
        gapless       = 1'b0;
        want_hold     = 1'b0;
        pixels_sent   = 0;
        settings_run  = 0;
        random_sent   = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size is one by one: every pixel comes straight back
        apb_access(1'b0, ADDR_SRC_WIDTH, '0);
        apb_access(1'b0, ADDR_SRC_HEIGHT, '0);
        send_pixel(flat_pixel(8'h00));
        send_pixel(in_t'(32'h00FF_0180));

        set_level(2, 2, n);
        repeat (4) send_pixel(flat_pixel(8'hFF));
        send_pixel(flat_pixel(8'h00));
        send_pixel(flat_pixel(8'h00));
        send_pixel(flat_pixel(8'h00));
        send_pixel(flat_pixel(8'h01));
        send_pixel(flat_pixel(8'h01));
        send_pixel(flat_pixel(8'h01));
        send_pixel(flat_pixel(8'h00));
        send_pixel(flat_pixel(8'h00));

        set_level(3, 3, n);
        repeat (n) send_pixel(random_pixel());

        set_level(0, 0, n);
        send_pixel(flat_pixel(8'hFF));
        send_pixel(in_t'(32'h807F_FE01));

        // receiver holds off while a long gapless level keeps coming
        set_level(32, 16, n);
        gapless   = 1'b1;
        want_hold = 1'b1;
        repeat (n) send_pixel(random_pixel());

        // opening stretch of clamped and widest levels, then restart
        set_level(8191, 1, n);
        gapless = ($urandom_range(0, 1) == 1);
        repeat (LARGE_RUN_PIXELS) send_pixel(random_pixel());

        set_level(1, 8191, n);
        gapless = ($urandom_range(0, 1) == 1);
        repeat (LARGE_RUN_PIXELS) send_pixel(random_pixel());

        set_level(MAX_WIDTH, 8191, n);
        gapless = ($urandom_range(0, 1) == 1);
        repeat (LARGE_RUN_PIXELS) send_pixel(random_pixel());

        while (random_sent < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                w_val = $urandom_range(1, 12);
                h_val = $urandom_range(1, 8);
            end else if (pick < 8) begin
                w_val = $urandom_range(13, 70);
                h_val = $urandom_range(1, 4);
            end else if (pick == 8) begin
                w_val = $urandom_range(0, 1);
                h_val = $urandom_range(0, 20);
            end else begin
                w_val = $urandom_range(0, 9);
                h_val = $urandom_range(0, 1);
            end
            set_level(w_val, h_val, n);
            gapless = ($urandom_range(0, 3) == 0);
            total   = n * $urandom_range(1, 3);
            if ($urandom_range(0, 4) == 0) begin
                total = $urandom_range(1, total);
            end
            if (total > RANDOM_PIXELS - random_sent) begin
                total = RANDOM_PIXELS - random_sent;
            end
            repeat (total) send_pixel(random_pixel());
            random_sent += total;
        end

        wait_idle();
        $display("run covered %0d source pixels over %0d size settings", pixels_sent,
                 settings_run);
        $display("%0d averaged pixels compared, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0) begin
            $display("mip_level_box_downsample_core verification clean");
        end else begin
            $display("mip_level_box_downsample_core verification failed");
        end
        $finish;
    end

endmodule
